// ===== design/gra_pkg.sv =====
// ----------------------------------------------------------------------------
// gra_pkg
// Shared constants and types for the glitch-rejecting burst averager.
// ----------------------------------------------------------------------------
`default_nettype none

package gra_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned KEPT_W        = 4;
  localparam int unsigned SLOTS_DEFAULT = 8;

  localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 16'd1000;
  localparam logic [SAMPLE_W-1:0] REF_RESET   = 16'd1000;

  typedef struct packed {
    logic                keep;
    logic [SAMPLE_W-1:0] value;
  } slot_rec_t;

  typedef enum logic [1:0] {
    BK_ACCUM,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/gra_intf.sv =====
// ----------------------------------------------------------------------------
// gra_intf
// Valid/ready channels for converter reads and burst means.
// ----------------------------------------------------------------------------
`default_nettype none

interface gra_sample_if;
  logic        valid;
  logic        ready;
  logic        read_ok;
  logic [15:0] sample;

  modport source (output valid, output read_ok, output sample, input ready);
  modport sink   (input valid, input read_ok, input sample, output ready);
endinterface

interface gra_mean_if;
  logic        valid;
  logic        ready;
  logic [15:0] average;
  logic [3:0]  kept_count;
  logic        held;

  modport source (output valid, output average, output kept_count, output held,
                  input ready);
  modport sink   (input valid, input average, input kept_count, input held,
                  output ready);
endinterface

`default_nettype wire

// ===== design/gra_front.sv =====
// ----------------------------------------------------------------------------
// gra_front
// Classifies converter reads against the reference and emits one slot record
// per finished slot.
// ----------------------------------------------------------------------------
`default_nettype none

module gra_front
  import gra_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata,
  gra_sample_if.sink               in_ch,
  output      logic                push,
  output      slot_rec_t           push_rec,
  input  wire logic                q_full
);

  logic [SAMPLE_W-1:0] delta_limit;
  logic [SAMPLE_W-1:0] reference_sample;
  logic                reread_pending;

  logic [SAMPLE_W-1:0] v_eff;
  logic [SAMPLE_W-1:0] mag;
  logic                in_limit;
  logic                accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    v_eff = (reread_pending && !in_ch.read_ok) ? '0 : in_ch.sample;
    mag   = (v_eff >= reference_sample) ? (v_eff - reference_sample)
                                        : (reference_sample - v_eff);
    in_limit = (mag <= delta_limit);
  end

  always_comb begin
    push           = accept && (reread_pending || !in_ch.read_ok || in_limit);
    push_rec.keep  = in_ch.read_ok ? in_limit : (reread_pending && in_limit);
    push_rec.value = v_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_limit      <= LIMIT_RESET;
      reference_sample <= REF_RESET;
      reread_pending   <= 1'b0;
    end else begin
      if (cfg_we) begin
        delta_limit <= cfg_wdata;
      end
      if (accept) begin
        if (reread_pending) begin
          reread_pending   <= 1'b0;
          reference_sample <= v_eff;
        end else if (in_ch.read_ok) begin
          if (in_limit) begin
            reference_sample <= v_eff;
          end else begin
            reread_pending <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gra_queue.sv =====
// ----------------------------------------------------------------------------
// gra_queue
// Two-entry queue of slot records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gra_queue
  import gra_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire slot_rec_t push_rec,
  output      logic      full,
  input  wire logic      pop,
  output      logic      not_empty,
  output      slot_rec_t head
);

  slot_rec_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gra_back.sv =====
// ----------------------------------------------------------------------------
// gra_back
// Accumulates slot records over a burst, divides the sum by the kept count
// one quotient bit per cycle and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gra_back
  import gra_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  output      logic      pop,
  input  wire logic      not_empty,
  input  wire slot_rec_t head,
  gra_mean_if.source     out_ch
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(SLOTS);
  localparam int unsigned STEP_W = $clog2(SUM_W);

  back_state_t         state;
  back_state_t         state_next;

  logic [SLOT_W-1:0]   slot_index;
  logic [SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]    kept_samples;
  logic [SAMPLE_W-1:0] previous_mean;

  logic [SUM_W-1:0]    dividend;
  logic [CNT_W-1:0]    divisor;
  logic [CNT_W-1:0]    remainder;
  logic [STEP_W-1:0]   step;
  logic                is_held;

  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]    cnt_next;
  logic                last_slot;
  logic [CNT_W:0]      rem_shift;
  logic                q_bit;
  logic                out_free;
  logic [CNT_W+KEPT_W-1:0] kept_ext;

  logic [SAMPLE_W-1:0] out_average;
  logic [KEPT_W-1:0]   out_kept;
  logic                out_held;
  logic                out_valid;

  assign out_ch.valid      = out_valid;
  assign out_ch.average    = out_average;
  assign out_ch.kept_count = out_kept;
  assign out_ch.held       = out_held;

  assign out_free = !out_valid || out_ch.ready;
  assign pop      = (state == BK_ACCUM) && not_empty;
  assign kept_ext = {{KEPT_W{1'b0}}, divisor};

  always_comb begin
    sum_next  = running_sum + (head.keep ? SUM_W'(head.value) : '0);
    cnt_next  = kept_samples + CNT_W'(head.keep);
    last_slot = (slot_index == SLOT_W'(SLOTS - 1));
    rem_shift = {remainder, dividend[SUM_W-1]};
    q_bit     = (rem_shift >= {1'b0, divisor});
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_ACCUM: begin
        if (pop && last_slot) begin
          state_next = (cnt_next == '0) ? BK_EMIT : BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == '0) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_ACCUM;
        end
      end
      default: state_next = BK_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index    <= '0;
      running_sum   <= '0;
      kept_samples  <= '0;
      previous_mean <= '0;
      out_valid     <= 1'b0;
    end else begin
      if ((state == BK_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_ACCUM: begin
          if (pop) begin
            if (last_slot) begin
              slot_index   <= '0;
              running_sum  <= '0;
              kept_samples <= '0;
            end else begin
              slot_index   <= slot_index + SLOT_W'(1);
              running_sum  <= sum_next;
              kept_samples <= cnt_next;
            end
          end
        end
        BK_EMIT: begin
          if (out_free) begin
            if (!is_held) begin
              previous_mean <= dividend[SAMPLE_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Divider datapath and result register payload
  always_ff @(posedge clk) begin
    case (state)
      BK_ACCUM: begin
        if (pop && last_slot) begin
          dividend  <= sum_next;
          divisor   <= cnt_next;
          remainder <= '0;
          step      <= STEP_W'(SUM_W - 1);
          is_held   <= (cnt_next == '0);
        end
      end
      BK_DIV: begin
        dividend  <= {dividend[SUM_W-2:0], q_bit};
        remainder <= q_bit ? CNT_W'(rem_shift - {1'b0, divisor}) : rem_shift[CNT_W-1:0];
        step      <= step - STEP_W'(1);
      end
      BK_EMIT: begin
        if (out_free) begin
          out_held <= is_held;
          if (is_held) begin
            out_average <= previous_mean;
            out_kept    <= '0;
          end else begin
            out_average <= dividend[SAMPLE_W-1:0];
            out_kept    <= kept_ext[KEPT_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/glitch_rejecting_burst_averager_top.sv =====
// ----------------------------------------------------------------------------
// glitch_rejecting_burst_averager_top
// Rejects glitched converter reads and emits one truncated mean per burst.
//
//   channel   | dir | transaction payload
//   ----------+-----+-------------------------------------
//   in_ch     | in  | read_ok, sample
//   out_ch    | out | average, kept_count, held
//   cfg       | in  | cfg_we, cfg_wdata -> delta_limit
//
// The front takes a read whenever the two-entry slot queue has room; the back
// retires one queued slot per cycle while it is accumulating. At the end of a
// burst the back runs the bit-serial divider and then loads the result
// register; a burst with nothing kept skips the divider.
// Reset (rst, synchronous) sets delta_limit and the reference to 1000 and
// clears the queue, the sums and the previous mean.
// A stalled result holds in the output register; the back then waits and the
// queue fills until the front drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module glitch_rejecting_burst_averager_top
  import gra_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata,
  gra_sample_if.sink               in_ch,
  gra_mean_if.source               out_ch
);

  logic      push;
  slot_rec_t push_rec;
  logic      q_full;
  logic      pop;
  logic      not_empty;
  slot_rec_t head;

  gra_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .push      (push),
    .push_rec  (push_rec),
    .q_full    (q_full)
  );

  gra_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  gra_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/glitch_rejecting_burst_averager_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glitch_rejecting_burst_averager_top_test
// Drives converter read outcomes into the averager under several delta_limit
// settings and idle/stall patterns. A scoreboard class tracks the reference
// sample, burst sums and slot position, predicts each burst mean, and checks
// every mean transaction in order against the predicted one.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [15:0] average;
  logic [3:0]  kept_count;
  logic        held;
} burst_mean_t;

class burst_mean_scoreboard;
  logic [15:0]  delta_limit;
  logic [15:0]  reference_sample;
  logic [15:0]  previous_mean;
  int unsigned  running_sum;
  int unsigned  kept_samples;
  int unsigned  slot_index;
  bit           reread_pending;
  burst_mean_t  pending_means[$];
  int unsigned  mismatches;

  function new();
    delta_limit      = gra_pkg::LIMIT_RESET;
    reference_sample = gra_pkg::REF_RESET;
    previous_mean    = '0;
    running_sum      = 0;
    kept_samples     = 0;
    slot_index       = 0;
    reread_pending   = 1'b0;
    mismatches       = 0;
  endfunction

  function bit within_limit(logic [15:0] v);
    int unsigned mag;
    mag = (v >= reference_sample) ? int'(v - reference_sample)
                                  : int'(reference_sample - v);
    return mag <= delta_limit;
  endfunction

  function void keep_sample(logic [15:0] v);
    running_sum  += v;
    kept_samples += 1;
  endfunction

  function void close_slot();
    burst_mean_t m;
    slot_index += 1;
    if (slot_index < gra_pkg::SLOTS_DEFAULT) return;
    if (kept_samples != 0) begin
      previous_mean = 16'(running_sum / kept_samples);
      m.average     = previous_mean;
      m.kept_count  = 4'(kept_samples);
      m.held        = 1'b0;
    end else begin
      m.average     = previous_mean;
      m.kept_count  = '0;
      m.held        = 1'b1;
    end
    pending_means.push_back(m);
    running_sum  = 0;
    kept_samples = 0;
    slot_index   = 0;
  endfunction

  function void note_read(bit ok, logic [15:0] sample);
    logic [15:0] v;
    v = ok ? sample : 16'd0;
    if (reread_pending) begin
      reread_pending = 1'b0;
      if (within_limit(v)) keep_sample(v);
      reference_sample = v;
      close_slot();
    end else if (!ok) begin
      close_slot();
    end else if (!within_limit(v)) begin
      reread_pending = 1'b1;
    end else begin
      keep_sample(v);
      reference_sample = v;
      close_slot();
    end
  endfunction

  function void check_mean(logic [15:0] average, logic [3:0] kept_count, logic held);
    burst_mean_t want;
    if (pending_means.size() == 0) begin
      mismatches += 1;
      if (mismatches <= 10)
        $display("unexpected mean: average %0d kept_count %0d held %0d",
                 average, kept_count, held);
      return;
    end
    want = pending_means.pop_front();
    if (want.average !== average || want.kept_count !== kept_count ||
        want.held !== held) begin
      mismatches += 1;
      if (mismatches <= 10)
        $display("mean mismatch: expected average %0d kept_count %0d held %0d, got %0d %0d %0d",
                 want.average, want.kept_count, want.held, average, kept_count, held);
    end
  endfunction
endclass

module glitch_rejecting_burst_averager_top_test;
  import gra_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned READS_PER_PHASE = 172;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [SAMPLE_W-1:0] cfg_wdata;
  logic                mean_ready = 1'b0;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles       = 0;
  bit          dead_burst         = 1'b0;

  burst_mean_scoreboard sb = new();

  gra_sample_if in_ch();
  gra_mean_if   out_ch();

  assign out_ch.ready = mean_ready;

  glitch_rejecting_burst_averager_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_mean(out_ch.average, out_ch.kept_count, out_ch.held);
    mean_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("glitch_rejecting_burst_averager_top_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;  receiver_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 58; receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;  receiver_stall_pct = 58;
      end
      default: begin
        sender_idle_pct = 16; receiver_stall_pct = 16;
      end
    endcase
  endtask

  task automatic send_read(bit ok, logic [15:0] sample);
    int unsigned gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.read_ok <= ok;
    in_ch.sample  <= sample;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_read(ok, sample);
  endtask

  // hold the sender until every predicted mean has come back
  task automatic drain(int unsigned extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_means.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] limit);
    drain(DRAIN_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.delta_limit = limit;
  endtask

  task automatic pick_read(output bit ok, output logic [15:0] sample);
    int unsigned kind;
    int          span;
    int          offset;
    int          value;
    if (sb.slot_index == 0 && !sb.reread_pending)
      dead_burst = ($urandom_range(0, 99) < 6);
    ok   = dead_burst ? 1'b0 : ($urandom_range(0, 99) >= 8);
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      span   = int'(sb.delta_limit) + int'(sb.delta_limit) / 2 + 1;
      offset = int'($urandom_range(0, 2 * span)) - span;
      value  = int'(sb.reference_sample) + offset;
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
      sample = 16'(value);
    end else if (kind < 85) begin
      sample = 16'($urandom);
    end else begin
      sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
  endtask

  task automatic run_directed();
    send_read(1'b1, 16'd1000);
    send_read(1'b0, 16'h5A5A);
    send_read(1'b1, 16'hFFFF);
    send_read(1'b1, 16'hFFFF);
    send_read(1'b1, 16'hFFFF);
    send_read(1'b1, 16'd0);
    send_read(1'b0, 16'hABCD);
    send_read(1'b1, 16'd500);
    send_read(1'b1, 16'd3000);
    send_read(1'b1, 16'd1200);
    send_read(1'b1, 16'd1100);
    // all reads fail: repeat the previous mean
    for (int i = 0; i < 8; i++)
      send_read(1'b0, (i % 2 == 0) ? 16'hFFFF : 16'h0000);
  endtask

  initial begin
    logic [15:0] limits[PHASES];
    idle_mode_t  modes[PHASES];
    bit          ok;
    logic [15:0] sample;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.read_ok = 1'b0;
    in_ch.sample  = '0;

    limits[0] = 16'd1000;
    limits[1] = 16'd0;
    limits[2] = 16'hFFFF;
    limits[3] = 16'($urandom_range(1, 65534));
    limits[4] = 16'd1;
    limits[5] = 16'($urandom_range(2, 400));
    modes[0]  = IDLE_NONE;
    modes[1]  = IDLE_SENDER;
    modes[2]  = IDLE_RECEIVER;
    modes[3]  = IDLE_BOTH;
    modes[4]  = IDLE_SENDER;
    modes[5]  = IDLE_RECEIVER;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_idle(IDLE_NONE);
    write_limit(LIMIT_RESET);
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      write_limit(limits[p]);
      set_idle(modes[p]);
      for (int i = 0; i < READS_PER_PHASE; i++) begin
        if (p == 3 && i == 90) drain(1);
        if (i == READS_PER_PHASE / 2 && p != 0) set_idle(IDLE_NONE);
        if (i == READS_PER_PHASE / 2 + 30) set_idle(modes[p]);
        pick_read(ok, sample);
        send_read(ok, sample);
      end
    end

    drain(DRAIN_CYCLES);
    if (sb.mismatches == 0 && sb.pending_means.size() == 0) begin
      $display("glitch_rejecting_burst_averager_top_test OK");
    end else begin
      $display("glitch_rejecting_burst_averager_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== glitch_rejecting_burst_averager_top.f =====
design/gra_pkg.sv
design/gra_intf.sv
design/gra_front.sv
design/gra_queue.sv
design/gra_back.sv
design/glitch_rejecting_burst_averager_top.sv
tb/glitch_rejecting_burst_averager_top_test.sv
